// ===== sv/prr_pkg.sv =====
// prr_pkg: shared types and constants of the preemption record/replay unit.
// No dependencies; all other files but prr_ram refer to it by scoped names.
package prr_pkg;

   localparam int CMD_W      = 2;
   localparam int CLOCK_W    = 64;
   localparam int IDX_W      = 10;
   localparam int CNT_OUT_W  = 11;
   localparam int OVF_W      = 32;
   localparam int STATUS_W   = 2;
   localparam int MODE_W     = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CSR_REG_MODE = 1'b0;

   typedef enum logic [CMD_W-1:0] {
      CMD_DECIDE = 2'd0,
      CMD_BEGIN  = 2'd1,
      CMD_LOAD   = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_OFF    = 2'd0,
      MODE_RECORD = 2'd1,
      MODE_REPLAY = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

endpackage

// ===== sv/prr_if.sv =====
// prr_if: request and response channel interfaces (valid/ready plus payload).
// Depends on prr_pkg for field widths.
interface prr_req_if;
   logic                         valid;
   logic                         ready;
   logic [prr_pkg::CMD_W-1:0]    cmd;
   logic                         want;
   logic [prr_pkg::CLOCK_W-1:0]  logical_clock;
   logic [prr_pkg::CLOCK_W-1:0]  point_value;
   logic [prr_pkg::CLOCK_W-1:0]  epoch_value;
   logic [prr_pkg::IDX_W-1:0]    read_index;

   modport source (output valid, cmd, want, logical_clock, point_value, epoch_value,
                   read_index, input ready);
   modport sink   (input valid, cmd, want, logical_clock, point_value, epoch_value,
                   read_index, output ready);
endinterface

interface prr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          preempt;
   logic [prr_pkg::STATUS_W-1:0]  status;
   logic [prr_pkg::CNT_OUT_W-1:0] point_count;
   logic [prr_pkg::CNT_OUT_W-1:0] replay_position;
   logic [prr_pkg::OVF_W-1:0]     overflow_count;
   logic [prr_pkg::CLOCK_W-1:0]   epoch_now;
   logic [prr_pkg::CLOCK_W-1:0]   read_point;

   modport source (output valid, preempt, status, point_count, replay_position,
                   overflow_count, epoch_now, read_point, input ready);
   modport sink   (input valid, preempt, status, point_count, replay_position,
                   overflow_count, epoch_now, read_point, output ready);
endinterface

// ===== sv/prr_ram.sv =====
// prr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module prr_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/prr_ctrl.sv =====
// prr_ctrl: two-state sequencer for the request/response handshake.
// Depends on prr_pkg; drives capture and commit commands into prr_datapath.
module prr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output prr_pkg::ctrl_cmd_type ctrl
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      commit;

   assign req_ready    = (state_ff == S_IDLE);
   assign commit       = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign ctrl.capture = req_valid && req_ready;
   assign ctrl.commit  = commit;
   assign rsp_valid    = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (commit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/prr_datapath.sv =====
// prr_datapath: mode register, counters, point store and result registers.
// Depends on prr_pkg and prr_ram; steered by prr_ctrl commands.
module prr_datapath #(
   parameter int STORE_DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  prr_pkg::ctrl_cmd_type              ctrl,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [prr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [prr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [prr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   input  logic [prr_pkg::CMD_W-1:0]          req_cmd,
   input  logic                               req_want,
   input  logic [prr_pkg::CLOCK_W-1:0]        req_logical_clock,
   input  logic [prr_pkg::CLOCK_W-1:0]        req_point_value,
   input  logic [prr_pkg::CLOCK_W-1:0]        req_epoch_value,
   input  logic [prr_pkg::IDX_W-1:0]          req_read_index,
   output logic                               rsp_preempt,
   output logic [prr_pkg::STATUS_W-1:0]       rsp_status,
   output logic [prr_pkg::CNT_OUT_W-1:0]      rsp_point_count,
   output logic [prr_pkg::CNT_OUT_W-1:0]      rsp_replay_position,
   output logic [prr_pkg::OVF_W-1:0]          rsp_overflow_count,
   output logic [prr_pkg::CLOCK_W-1:0]        rsp_epoch_now,
   output logic [prr_pkg::CLOCK_W-1:0]        rsp_read_point
);

   localparam int ADDR_W    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W     = $clog2(STORE_DEPTH + 1);
   localparam int CMP_W     = (CNT_W > prr_pkg::IDX_W) ? CNT_W : prr_pkg::IDX_W;
   localparam int ADDR_WIDE = (ADDR_W > prr_pkg::IDX_W) ? ADDR_W : prr_pkg::IDX_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);

   logic [prr_pkg::MODE_W-1:0]   mode_ff;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [CNT_W-1:0]             cursor_ff, cursor_in;
   logic [prr_pkg::OVF_W-1:0]    dropped_ff, dropped_in;
   logic [prr_pkg::CLOCK_W-1:0]  epoch_ff, epoch_in;

   prr_pkg::cmd_type             item_cmd_ff;
   logic                         item_want_ff;
   logic [prr_pkg::CLOCK_W-1:0]  item_clock_ff;
   logic [prr_pkg::CLOCK_W-1:0]  item_point_ff;
   logic [prr_pkg::CLOCK_W-1:0]  item_epoch_ff;
   logic [prr_pkg::IDX_W-1:0]    item_ridx_ff;

   logic                         preempt_ff, preempt_in;
   prr_pkg::status_type          status_ff, status_in;
   logic [prr_pkg::CLOCK_W-1:0]  rpoint_ff, rpoint_in;

   logic                         mem_wr_en;
   logic [prr_pkg::CLOCK_W-1:0]  mem_wr_data;
   logic [ADDR_W-1:0]            mem_rd_addr;
   logic [prr_pkg::CLOCK_W-1:0]  mem_q;
   logic [ADDR_WIDE-1:0]         ridx_wide;
   logic                         full;
   logic                         csr_wr;

   // csr
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= prr_pkg::MODE_OFF;
      end else if (csr_wr && (csr_paddr[2] == prr_pkg::CSR_REG_MODE)) begin
         mode_ff <= csr_pwdata[prr_pkg::MODE_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == prr_pkg::CSR_REG_MODE) ?
                       prr_pkg::CSR_DATA_W'(mode_ff) : '0;

   // store read is issued with the accepted request
   assign ridx_wide   = ADDR_WIDE'(req_read_index);
   assign mem_rd_addr = (prr_pkg::cmd_type'(req_cmd) == prr_pkg::CMD_READ) ?
                        ridx_wide[ADDR_W-1:0] : cursor_ff[ADDR_W-1:0];

   prr_ram #(
      .WIDTH (prr_pkg::CLOCK_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (mem_wr_data),
      .rd_en   (ctrl.capture),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_q)
   );

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         item_cmd_ff   <= prr_pkg::cmd_type'(req_cmd);
         item_want_ff  <= req_want;
         item_clock_ff <= req_logical_clock;
         item_point_ff <= req_point_value;
         item_epoch_ff <= req_epoch_value;
         item_ridx_ff  <= req_read_index;
      end
   end

   assign full = (count_ff == DEPTH_CNT);

   always_comb begin
      count_in    = count_ff;
      cursor_in   = cursor_ff;
      dropped_in  = dropped_ff;
      epoch_in    = epoch_ff;
      preempt_in  = 1'b0;
      status_in   = prr_pkg::STAT_OK;
      rpoint_in   = '0;
      mem_wr_en   = 1'b0;
      mem_wr_data = item_point_ff;
      unique case (item_cmd_ff)
         prr_pkg::CMD_DECIDE: begin
            case (prr_pkg::mode_type'(mode_ff))
               prr_pkg::MODE_RECORD: begin
                  preempt_in = item_want_ff;
                  if (item_want_ff) begin
                     if (!full) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = item_clock_ff;
                        count_in    = count_ff + 1'b1;
                     end else if (dropped_ff != '1) begin
                        dropped_in = dropped_ff + 1'b1;
                     end
                  end
               end
               prr_pkg::MODE_REPLAY: begin
                  if ((cursor_ff < count_ff) && (item_clock_ff >= mem_q)) begin
                     cursor_in  = cursor_ff + 1'b1;
                     preempt_in = 1'b1;
                  end
               end
               default: preempt_in = item_want_ff;
            endcase
         end
         prr_pkg::CMD_BEGIN: begin
            epoch_in   = item_epoch_ff;
            count_in   = '0;
            cursor_in  = '0;
            dropped_in = '0;
         end
         prr_pkg::CMD_LOAD: begin
            if (!full) begin
               mem_wr_en = 1'b1;
               count_in  = count_ff + 1'b1;
            end else begin
               status_in = prr_pkg::STAT_FULL;
            end
         end
         prr_pkg::CMD_READ: begin
            if (CMP_W'(item_ridx_ff) < CMP_W'(count_ff)) begin
               rpoint_in = mem_q;
            end else begin
               status_in = prr_pkg::STAT_RANGE;
            end
         end
         default: ;
      endcase
      if (!ctrl.commit) begin
         mem_wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         cursor_ff  <= '0;
         dropped_ff <= '0;
         epoch_ff   <= '0;
      end else if (ctrl.commit) begin
         count_ff   <= count_in;
         cursor_ff  <= cursor_in;
         dropped_ff <= dropped_in;
         epoch_ff   <= epoch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         preempt_ff <= preempt_in;
         status_ff  <= status_in;
         rpoint_ff  <= rpoint_in;
      end
   end

   // counters only move on commit, so they equal the post-request values on rsp
   assign rsp_preempt         = preempt_ff;
   assign rsp_status          = status_ff;
   assign rsp_point_count     = prr_pkg::CNT_OUT_W'(count_ff);
   assign rsp_replay_position = prr_pkg::CNT_OUT_W'(cursor_ff);
   assign rsp_overflow_count  = dropped_ff;
   assign rsp_epoch_now       = epoch_ff;
   assign rsp_read_point      = rpoint_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("point count beyond store depth");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= count_ff)
      else $error("replay cursor beyond point count");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      (dropped_ff != '0) |-> full)
      else $error("dropped requests while store has room");

   a_load_appends: assert property (@(posedge clock) disable iff (reset)
      (ctrl.commit && (item_cmd_ff == prr_pkg::CMD_LOAD) && !full)
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("load into free store did not append");
`endif

endmodule

// ===== sv/preemption_record_replay_unit.sv =====
// preemption_record_replay_unit: top level, joins prr_ctrl and prr_datapath.
// Depends on prr_pkg, prr_if (channel interfaces), prr_ctrl, prr_datapath, prr_ram.
//
//   channel  | dir | handshake              | contents
//   req_port | in  | valid/ready            | cmd, want, logical_clock, point_value,
//            |     |                        | epoch_value, read_index
//   rsp_port | out | valid/ready            | preempt, status, point_count,
//            |     |                        | replay_position, overflow_count, epoch_now,
//            |     |                        | read_point
//   csr_*    | in  | APB psel/penable       | operating_mode at byte address 0
//
// Per request, the accept cycle issues the point-store read; the commit, in state
// S_EXEC, compares against the registered read data, updates the counters and
// writes the store. A result held at rsp_port stalls that commit; one further
// request is taken meanwhile. Synchronous reset clears mode, counters and
// handshake state; the point store is not cleared and needs no clearing pass.
module preemption_record_replay_unit #(
   parameter int STORE_DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   prr_req_if.sink                          req_port,
   prr_rsp_if.source                        rsp_port,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [prr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [prr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [prr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   prr_pkg::ctrl_cmd_type ctrl;

   assign csr_pready = 1'b1;

   prr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .ctrl      (ctrl)
   );

   prr_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (ctrl),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .req_cmd             (req_port.cmd),
      .req_want            (req_port.want),
      .req_logical_clock   (req_port.logical_clock),
      .req_point_value     (req_port.point_value),
      .req_epoch_value     (req_port.epoch_value),
      .req_read_index      (req_port.read_index),
      .rsp_preempt         (rsp_port.preempt),
      .rsp_status          (rsp_port.status),
      .rsp_point_count     (rsp_port.point_count),
      .rsp_replay_position (rsp_port.replay_position),
      .rsp_overflow_count  (rsp_port.overflow_count),
      .rsp_epoch_now       (rsp_port.epoch_now),
      .rsp_read_point      (rsp_port.read_point)
   );

endmodule

// ===== verif/tb_preemption_record_replay_unit.sv =====
// Testbench for preemption_record_replay_unit: random and directed requests against a
// built-in predictor of the point store, counters and epoch, checked field by field.
// Depends on prr_pkg, prr_if (channel interfaces) and the RTL of the unit.
module tb_preemption_record_replay_unit;

   localparam int STORE_DEPTH = 1024;
   localparam int QUIET_LIMIT = 2000;

   typedef logic [prr_pkg::CLOCK_W-1:0]    word_type;
   typedef logic [prr_pkg::IDX_W-1:0]      index_type;
   typedef logic [prr_pkg::MODE_W-1:0]     mode_field_type;
   typedef logic [prr_pkg::CNT_OUT_W-1:0]  count_type;
   typedef logic [prr_pkg::CSR_ADDR_W-1:0] addr_type;

   localparam mode_field_type MODE_SPARE = 2'd3;
   localparam addr_type MODE_ADDR = addr_type'(4 * prr_pkg::CSR_REG_MODE);

   typedef struct {
      prr_pkg::cmd_type    cmd;
      logic                want;
      word_type            tick;
      word_type            point;
      word_type            epoch;
      index_type           index;
   } request_type;

   typedef struct {
      logic                       preempt;
      prr_pkg::status_type        status;
      count_type                  count;
      count_type                  position;
      logic [prr_pkg::OVF_W-1:0]  dropped;
      word_type                   epoch;
      word_type                   point;
   } outcome_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   addr_type csr_paddr;
   logic [prr_pkg::CSR_DATA_W-1:0] csr_pwdata, csr_prdata;

   prr_req_if req_bus();
   prr_rsp_if rsp_bus();

   preemption_record_replay_unit #(.STORE_DEPTH(STORE_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_bus),
      .rsp_port    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   word_type                   shadow_points [STORE_DEPTH];
   int unsigned                shadow_count = 0;
   int unsigned                shadow_cursor = 0;
   logic [prr_pkg::OVF_W-1:0]  shadow_dropped = '0;
   word_type                   shadow_epoch = '0;
   mode_field_type             shadow_mode = prr_pkg::MODE_OFF;

   outcome_type outcomes_due [$];
   int       mismatches = 0;
   int       items_sent = 0;
   int       send_idle_pct = 0;
   int       stall_pct = 0;
   int       hold_off_request = 0;
   int       hold_off_left = 0;
   int       quiet = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic report_mismatch(string what, logic [63:0] seen, logic [63:0] wanted);
      $display("MISMATCH %s: got %h, wanted %h", what, seen, wanted);
      mismatches++;
   endtask

   function automatic outcome_type predict_outcome(request_type r);
      outcome_type o;
      o.preempt = 1'b0;
      o.status  = prr_pkg::STAT_OK;
      o.point   = '0;
      case (r.cmd)
         prr_pkg::CMD_DECIDE: begin
            if (shadow_mode == prr_pkg::MODE_RECORD) begin
               if (r.want) begin
                  if (shadow_count < STORE_DEPTH) begin
                     shadow_points[index_type'(shadow_count)] = r.tick;
                     shadow_count++;
                  end else if (shadow_dropped != '1) begin
                     shadow_dropped++;
                  end
               end
               o.preempt = r.want;
            end else if (shadow_mode == prr_pkg::MODE_REPLAY) begin
               if (shadow_cursor < shadow_count &&
                   r.tick >= shadow_points[index_type'(shadow_cursor)]) begin
                  shadow_cursor++;
                  o.preempt = 1'b1;
               end
            end else begin
               o.preempt = r.want;
            end
         end
         prr_pkg::CMD_BEGIN: begin
            shadow_epoch   = r.epoch;
            shadow_count   = 0;
            shadow_cursor  = 0;
            shadow_dropped = '0;
         end
         prr_pkg::CMD_LOAD: begin
            if (shadow_count < STORE_DEPTH) begin
               shadow_points[index_type'(shadow_count)] = r.point;
               shadow_count++;
            end else begin
               o.status = prr_pkg::STAT_FULL;
            end
         end
         default: begin
            if (r.index < shadow_count) begin
               o.point = shadow_points[r.index];
            end else begin
               o.status = prr_pkg::STAT_RANGE;
            end
         end
      endcase
      o.count    = count_type'(shadow_count);
      o.position = count_type'(shadow_cursor);
      o.dropped  = shadow_dropped;
      o.epoch    = shadow_epoch;
      return o;
   endfunction

   task automatic check_outcome();
      outcome_type e;
      if (outcomes_due.size() == 0) begin
         report_mismatch("result with nothing pending", 64'(rsp_bus.status), '0);
         return;
      end
      e = outcomes_due.pop_front();
      if (rsp_bus.preempt !== e.preempt)
         report_mismatch("preempt", 64'(rsp_bus.preempt), 64'(e.preempt));
      if (rsp_bus.status !== e.status)
         report_mismatch("status", 64'(rsp_bus.status), 64'(e.status));
      if (rsp_bus.point_count !== e.count)
         report_mismatch("point_count", 64'(rsp_bus.point_count), 64'(e.count));
      if (rsp_bus.replay_position !== e.position)
         report_mismatch("replay_position", 64'(rsp_bus.replay_position), 64'(e.position));
      if (rsp_bus.overflow_count !== e.dropped)
         report_mismatch("overflow_count", 64'(rsp_bus.overflow_count), 64'(e.dropped));
      if (rsp_bus.epoch_now !== e.epoch)
         report_mismatch("epoch_now", rsp_bus.epoch_now, e.epoch);
      if (rsp_bus.read_point !== e.point)
         report_mismatch("read_point", rsp_bus.read_point, e.point);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) check_outcome();
   end

   // receiver: random stalls, plus long hold-offs on demand
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request > 0) begin
            hold_off_left = hold_off_request;
            hold_off_request = 0;
         end
         if (hold_off_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_off_left--;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("preemption_record_replay_unit verification failed");
      $finish;
   end

   task automatic send_request(request_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.cmd           = r.cmd;
      req_bus.want          = r.want;
      req_bus.logical_clock = r.tick;
      req_bus.point_value   = r.point;
      req_bus.epoch_value   = r.epoch;
      req_bus.read_index    = r.index;
      req_bus.valid         = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      outcomes_due.push_back(predict_outcome(r));
      items_sent++;
   endtask

   function automatic request_type noise_request(prr_pkg::cmd_type c);
      request_type r;
      r.cmd   = c;
      r.want  = 1'($urandom_range(1));
      r.tick  = rand64();
      r.point = rand64();
      r.epoch = rand64();
      r.index = index_type'($urandom_range(STORE_DEPTH - 1));
      return r;
   endfunction

   task automatic offer_decide(logic w, logic [63:0] t);
      request_type r;
      r = noise_request(prr_pkg::CMD_DECIDE);
      r.want = w;
      r.tick = t;
      send_request(r);
   endtask

   task automatic offer_epoch(logic [63:0] e);
      request_type r;
      r = noise_request(prr_pkg::CMD_BEGIN);
      r.epoch = e;
      send_request(r);
   endtask

   task automatic offer_load(logic [63:0] v);
      request_type r;
      r = noise_request(prr_pkg::CMD_LOAD);
      r.point = v;
      send_request(r);
   endtask

   task automatic offer_read(index_type i);
      request_type r;
      r = noise_request(prr_pkg::CMD_READ);
      r.index = i;
      send_request(r);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_operating_mode(mode_field_type m);
      logic [prr_pkg::CSR_DATA_W-1:0] data;
      wait_drained();
      data = $urandom();
      data[prr_pkg::MODE_W-1:0] = m;
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = MODE_ADDR;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      shadow_mode = m;
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata[prr_pkg::MODE_W-1:0] !== m)
         report_mismatch("operating_mode readback", 64'(csr_prdata), 64'(m));
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   function automatic logic [63:0] pick_replay_tick();
      logic [63:0] p;
      int unsigned r;
      r = $urandom_range(99);
      if (shadow_cursor >= shadow_count) return rand64();
      p = shadow_points[index_type'(shadow_cursor)];
      if (r < 40) return p;
      if (r < 70) return p + 64'($urandom_range(1, 1000));
      if (r < 88) return p - 64'($urandom_range(1, 3));
      return rand64();
   endfunction

   task automatic test_directed();
      offer_decide(1'b1, '0);
      offer_decide(1'b0, '1);
      offer_read('0);
      offer_load('0);
      offer_load('1);
      offer_read(10'd0);
      offer_read(10'd1);
      offer_read(10'd2);
      offer_read('1);
      offer_epoch('1);
      offer_read(10'd0);
      set_operating_mode(prr_pkg::MODE_RECORD);
      offer_decide(1'b1, 64'd5);
      offer_decide(1'b0, 64'd7);
      offer_decide(1'b1, '1);
      offer_load(64'd10);
      set_operating_mode(prr_pkg::MODE_REPLAY);
      offer_decide(1'b1, 64'd4);
      offer_decide(1'b0, 64'd5);
      offer_decide(1'b1, 64'd0);
      offer_decide(1'b0, '1);
      offer_decide(1'b0, 64'd10);
      offer_decide(1'b1, '1);
      offer_load(64'd3);
      offer_decide(1'b0, 64'd3);
      set_operating_mode(MODE_SPARE);
      offer_decide(1'b1, rand64());
      offer_decide(1'b0, rand64());
      offer_epoch('0);
   endtask

   // receiver blocked for a long stretch while requests keep coming
   task automatic test_backpressure();
      int keep_idle, keep_stall;
      keep_idle  = send_idle_pct;
      keep_stall = stall_pct;
      set_operating_mode(prr_pkg::MODE_RECORD);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off_request = 60;
      repeat (16) begin
         if ($urandom_range(1)) offer_decide(1'($urandom_range(1)), rand64());
         else offer_read(index_type'($urandom_range(STORE_DEPTH - 1)));
      end
      wait_drained();
      send_idle_pct = keep_idle;
      stall_pct = keep_stall;
   endtask

   // fill the store, push past full, then replay the first points
   task automatic test_store_limits();
      logic [63:0] t;
      int unsigned r;
      set_operating_mode(prr_pkg::MODE_RECORD);
      offer_epoch(rand64());
      t = 64'($urandom());
      while (shadow_count < STORE_DEPTH) begin
         t += 64'($urandom_range(1, 500));
         r = $urandom_range(99);
         if (r < 55) offer_decide(1'b1, t);
         else if (r < 97) offer_load(t);
         else if (r < 98) offer_decide(1'b0, t);
         else offer_read(index_type'($urandom_range(STORE_DEPTH - 1)));
      end
      repeat (3) offer_load(rand64());
      repeat (3) offer_decide(1'b1, rand64());
      offer_decide(1'b0, rand64());
      offer_read('1);
      offer_read('0);
      send_idle_pct = 51;
      stall_pct = 15;
      set_operating_mode(prr_pkg::MODE_REPLAY);
      repeat (12) begin
         r = $urandom_range(99);
         if (r < 88) offer_decide(1'($urandom_range(1)), pick_replay_tick());
         else if (r < 96) offer_read(index_type'($urandom_range(STORE_DEPTH - 1)));
         else offer_load(rand64());
      end
      offer_read('1);
   endtask

   task automatic run_session();
      logic [63:0] t;
      int unsigned n, r, guard;
      r = $urandom_range(99);
      if (r < 75) set_operating_mode(prr_pkg::MODE_RECORD);
      else if (r < 88) set_operating_mode(prr_pkg::MODE_OFF);
      else set_operating_mode(MODE_SPARE);
      offer_epoch(rand64());
      n = $urandom_range(0, 24);
      t = rand64() >> $urandom_range(0, 63);
      repeat (n) begin
         t += 64'($urandom_range(0, 5000));
         r = $urandom_range(99);
         if (r < 65) offer_decide($urandom_range(99) < 80, t);
         else if (r < 85) offer_load(t);
         else offer_read(index_type'($urandom_range(0, 31)));
      end
      set_operating_mode(prr_pkg::MODE_REPLAY);
      guard = 0;
      while (shadow_cursor < shadow_count && guard < 4 * shadow_count + 8) begin
         r = $urandom_range(99);
         if (r < 80) offer_decide(1'($urandom_range(1)), pick_replay_tick());
         else if (r < 94) offer_read(index_type'($urandom_range(0, 31)));
         else offer_load(rand64());
         guard++;
      end
      repeat ($urandom_range(1, 2)) offer_decide(1'($urandom_range(1)), rand64());
   endtask

   task automatic run_noise();
      set_operating_mode(mode_field_type'($urandom_range(3)));
      repeat ($urandom_range(5, 20))
         send_request(noise_request(prr_pkg::cmd_type'($urandom_range(3))));
   endtask

   task automatic test_random_sessions(int target);
      int stop;
      stop = items_sent + target;
      while (items_sent < stop) begin
         if ($urandom_range(99) < 70) run_session();
         else run_noise();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd = prr_pkg::CMD_DECIDE;
      req_bus.want = 1'b0;
      req_bus.logical_clock = '0;
      req_bus.point_value = '0;
      req_bus.epoch_value = '0;
      req_bus.read_index = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 15;
      stall_pct = 51;
      test_directed();
      test_backpressure();
      test_store_limits();
      send_idle_pct = 15;
      stall_pct = 51;
      test_random_sessions(25);
      send_idle_pct = 51;
      stall_pct = 15;
      test_random_sessions(25);
      send_idle_pct = 0;
      stall_pct = 0;
      test_random_sessions(25);

      wait_drained();
      repeat (8) @(posedge clock);
      if (outcomes_due.size() != 0)
         report_mismatch("results never returned", 64'(outcomes_due.size()), '0);
      if (mismatches == 0) begin
         $display("preemption_record_replay_unit verification clean");
      end else begin
         $display("preemption_record_replay_unit verification failed");
      end
      $finish;
   end

endmodule
